// ===== hdl/bpts_pkg.sv =====
// Package for the bitmap priority task scheduler.
// Holds the field widths, action and switch codes and the controller/datapath structs.
// No dependencies.
package bpts_pkg;

   localparam int TASK_W  = 5;
   localparam int TIME_W  = 32;
   localparam int ACT_W   = 3;
   localparam int KIND_W  = 2;
   localparam int NEST_W  = 8;

   localparam logic [NEST_W-1:0] NEST_MAX    = '1;
   localparam logic [TASK_W-1:0] IDLE_RESET  = 5'd31;

   // Action codes carried on the request channel.
   localparam logic [ACT_W-1:0] ACT_CREATE  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_DELAY   = 3'd1;
   localparam logic [ACT_W-1:0] ACT_SUSPEND = 3'd2;
   localparam logic [ACT_W-1:0] ACT_RESUME  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_START   = 3'd5;
   localparam logic [ACT_W-1:0] ACT_IENTER  = 3'd6;
   localparam logic [ACT_W-1:0] ACT_IEXIT   = 3'd7;

   // Switch kinds reported on the response channel.
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TASK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INTR  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_START = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the accepted transaction
      logic tick_begin;  // advance time and nesting, rewind the delay walk
      logic walk_step;   // issue the next delay read of the walk
      logic exec;        // apply the action and reschedule
      logic out_load;    // move the staged result to the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic walk_done;
   } status_type;

endpackage

// ===== hdl/bpts_req_if.sv =====
// Request channel of the task scheduler: valid/ready handshake with the action payload.
// Depends on bpts_pkg.
interface bpts_req_if;
   import bpts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ACT_W-1:0]     action;
   logic [TASK_W-1:0]    task_id;
   logic [TIME_W-1:0]    delay_ticks;

   modport source (output valid, action, task_id, delay_ticks, input ready);
   modport sink   (input valid, action, task_id, delay_ticks, output ready);
endinterface

// ===== hdl/bpts_rsp_if.sv =====
// Response channel of the task scheduler: valid/ready handshake with the switch report.
// Depends on bpts_pkg.
interface bpts_rsp_if;
   import bpts_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    switch_kind;
   logic [TASK_W-1:0]    from_task;
   logic [TASK_W-1:0]    to_task;
   logic                 none_ready;
   logic [TASK_W-1:0]    current_task;
   logic [TIME_W-1:0]    system_time;

   modport source (output valid, switch_kind, from_task, to_task, none_ready,
                   current_task, system_time, input ready);
   modport sink   (input valid, switch_kind, from_task, to_task, none_ready,
                   current_task, system_time, output ready);
endinterface

// ===== hdl/bitmap_priority_task_scheduler.sv =====
// Bitmap priority task scheduler. A transaction is loaded, then executed, then moved to the
// output register once it is free; a tick first advances time and walks the delay memory, reading
// and decrementing one delay counter per cycle through the shared write port, before it executes.
// One transaction is in work at a time; a new one is accepted while the response waits.
// Synchronous reset clears all tasks, delays, time and nesting; idle task register is 31.
module bitmap_priority_task_scheduler #(
   parameter int NUM_TASKS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [bpts_pkg::TASK_W-1:0]  csr_wr_data,
   bpts_req_if.sink                     req,
   bpts_rsp_if.source                   rsp
);
   import bpts_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Controller.
   bpts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath.
   bpts_dp #(
      .NUM_TASKS (NUM_TASKS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_action       (req.action),
      .req_task_id      (req.task_id),
      .req_delay_ticks  (req.delay_ticks),
      .rsp_switch_kind  (rsp.switch_kind),
      .rsp_from_task    (rsp.from_task),
      .rsp_to_task      (rsp.to_task),
      .rsp_none_ready   (rsp.none_ready),
      .rsp_current_task (rsp.current_task),
      .rsp_system_time  (rsp.system_time)
   );

endmodule

// ===== hdl/bpts_ctrl.sv =====
// Controller state machine of the task scheduler: sequences load, tick walk, execute and output.
// Depends on bpts_pkg.
module bpts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  bpts_pkg::status_type status,
   output bpts_pkg::cmd_type    cmd
);
   import bpts_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BEGIN = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_EXEC  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_BEGIN;
            end
         end
         S_BEGIN: begin
            if (status.is_tick) begin
               cmd.tick_begin = 1'b1;
               state_in       = S_WALK;
            end else begin
               cmd.exec = 1'b1;
               state_in = S_DONE;
            end
         end
         S_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // The output valid flag is set on a load and cleared once the transaction is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hdl/bpts_dp.sv =====
// Datapath of the task scheduler: ready bitmap, delay memory, task state and result registers.
// Depends on bpts_pkg.
module bpts_dp #(
   parameter int NUM_TASKS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bpts_pkg::cmd_type            cmd,
   output bpts_pkg::status_type         status,
   input  logic                         csr_wr_en,
   input  logic [bpts_pkg::TASK_W-1:0]  csr_wr_data,
   input  logic [bpts_pkg::ACT_W-1:0]   req_action,
   input  logic [bpts_pkg::TASK_W-1:0]  req_task_id,
   input  logic [bpts_pkg::TIME_W-1:0]  req_delay_ticks,
   output logic [bpts_pkg::KIND_W-1:0]  rsp_switch_kind,
   output logic [bpts_pkg::TASK_W-1:0]  rsp_from_task,
   output logic [bpts_pkg::TASK_W-1:0]  rsp_to_task,
   output logic                         rsp_none_ready,
   output logic [bpts_pkg::TASK_W-1:0]  rsp_current_task,
   output logic [bpts_pkg::TIME_W-1:0]  rsp_system_time
);
   import bpts_pkg::*;

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CNT_W = $clog2(NUM_TASKS + 1);
   localparam logic [TASK_W:0]  TASK_LIMIT = (TASK_W + 1)'(NUM_TASKS);
   localparam logic [CNT_W-1:0] WALK_END   = CNT_W'(NUM_TASKS);

   // Configuration and scheduler state.
   logic [TASK_W-1:0]    idle_ff;
   logic [NUM_TASKS-1:0] mask_ff, mask_in;
   logic [TASK_W-1:0]    cur_ff, cur_in;
   logic [NEST_W-1:0]    nest_ff, nest_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic                 run_ff, run_in;

   // Captured transaction.
   logic [ACT_W-1:0]     act_ff;
   logic [TASK_W-1:0]    id_ff;
   logic [TIME_W-1:0]    ticks_ff;

   // Delay memory with a valid bit per entry; an entry not yet written reads as zero.
   logic [TIME_W-1:0]    delay_mem [NUM_TASKS];
   logic [NUM_TASKS-1:0] dvalid_ff;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [TIME_W-1:0]    wr_data;

   // Tick walk over the delay memory.
   logic [CNT_W-1:0]     walk_cnt_ff;
   logic                 walk_rd;
   logic                 rd_pend_ff;
   logic [IDX_W-1:0]     rd_addr_ff;
   logic [TIME_W-1:0]    rd_data_ff;
   logic                 rd_vld_ff;
   logic [TIME_W-1:0]    walk_val;
   logic                 walk_wr;
   logic                 walk_wake;

   // Execute step.
   logic                 id_ok;
   logic                 idle_ok;
   logic [NUM_TASKS-1:0] id_bit;
   logic [NUM_TASKS-1:0] cur_bit;
   logic [NUM_TASKS-1:0] idle_bit;
   logic [NUM_TASKS-1:0] exec_mask;
   logic                 exec_wr;
   logic [IDX_W-1:0]     exec_addr;
   logic [TIME_W-1:0]    exec_data;
   logic                 do_sched;
   logic                 do_start;
   logic [KIND_W-1:0]    sched_kind;
   logic                 found;
   logic [TASK_W-1:0]    sel;
   logic [NEST_W-1:0]    nest_dec;
   logic [NEST_W-1:0]    nest_exec;
   logic [KIND_W-1:0]    kind_c;
   logic [TASK_W-1:0]    to_c;
   logic                 none_c;
   logic [TASK_W-1:0]    cur_exec;

   // Staged result.
   logic [KIND_W-1:0]    res_kind_ff;
   logic [TASK_W-1:0]    res_from_ff;
   logic [TASK_W-1:0]    res_to_ff;
   logic                 res_none_ff;
   logic [TASK_W-1:0]    res_cur_ff;
   logic [TIME_W-1:0]    res_time_ff;

   assign status.is_tick   = (act_ff == ACT_TICK);
   assign status.walk_done = (walk_cnt_ff == WALK_END);

   // Idle task register.
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= IDLE_RESET;
      end else if (csr_wr_en) begin
         idle_ff <= csr_wr_data;
      end
   end

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= req_action;
         id_ff    <= req_task_id;
         ticks_ff <= req_delay_ticks;
      end
   end

   // Walk: read one delay per cycle, decrement it in the cycle after its read.
   assign walk_rd   = cmd.walk_step && (walk_cnt_ff != WALK_END);
   assign walk_val  = rd_vld_ff ? rd_data_ff : '0;
   assign walk_wr   = rd_pend_ff && (walk_val != '0);
   assign walk_wake = walk_wr && (walk_val == TIME_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_cnt_ff <= '0;
         rd_pend_ff  <= 1'b0;
      end else begin
         if (cmd.tick_begin) begin
            walk_cnt_ff <= '0;
         end else if (walk_rd) begin
            walk_cnt_ff <= walk_cnt_ff + CNT_W'(1);
         end
         rd_pend_ff <= walk_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (walk_rd) begin
         rd_addr_ff <= walk_cnt_ff[IDX_W-1:0];
         rd_data_ff <= delay_mem[walk_cnt_ff[IDX_W-1:0]];
         rd_vld_ff  <= dvalid_ff[walk_cnt_ff[IDX_W-1:0]];
      end
   end

   // Single write port shared by the walk and the execute step.
   always_comb begin
      wr_en   = walk_wr || (cmd.exec && exec_wr);
      wr_addr = walk_wr ? rd_addr_ff : exec_addr;
      wr_data = walk_wr ? (walk_val - TIME_W'(1)) : exec_data;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         delay_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff <= '0;
      end else if (wr_en) begin
         dvalid_ff[wr_addr] <= 1'b1;
      end
   end

   // Action decode and bitmap update.
   assign id_ok    = ({1'b0, id_ff} < TASK_LIMIT);
   assign idle_ok  = ({1'b0, idle_ff} < TASK_LIMIT);
   assign id_bit   = NUM_TASKS'(1) << id_ff[IDX_W-1:0];
   assign cur_bit  = NUM_TASKS'(1) << cur_ff[IDX_W-1:0];
   assign idle_bit = NUM_TASKS'(1) << idle_ff[IDX_W-1:0];
   assign nest_dec = (nest_ff != '0) ? (nest_ff - NEST_W'(1)) : '0;

   always_comb begin
      exec_mask  = mask_ff;
      exec_wr    = 1'b0;
      exec_addr  = id_ff[IDX_W-1:0];
      exec_data  = '0;
      do_sched   = 1'b0;
      do_start   = 1'b0;
      sched_kind = KIND_TASK;
      nest_exec  = nest_ff;
      unique case (act_ff)
         ACT_CREATE: begin
            if (id_ok) begin
               exec_wr   = 1'b1;
               exec_mask = mask_ff | id_bit;
            end
         end
         ACT_DELAY: begin
            if (ticks_ff != '0) begin
               exec_wr   = 1'b1;
               exec_addr = cur_ff[IDX_W-1:0];
               exec_data = ticks_ff;
               exec_mask = mask_ff & ~cur_bit;
               do_sched  = 1'b1;
            end
         end
         ACT_SUSPEND: begin
            if (id_ok) begin
               exec_wr   = 1'b1;
               exec_mask = mask_ff & ~id_bit;
               do_sched  = (cur_ff == id_ff);
            end
         end
         ACT_RESUME: begin
            if (id_ok) begin
               exec_wr   = 1'b1;
               exec_mask = mask_ff | id_bit;
               do_sched  = (cur_ff > id_ff);
            end
         end
         ACT_START: begin
            if (!run_ff) begin
               do_start = 1'b1;
               if (idle_ok) begin
                  exec_wr   = 1'b1;
                  exec_addr = idle_ff[IDX_W-1:0];
                  exec_mask = mask_ff | idle_bit;
               end
            end
         end
         ACT_IENTER: begin
            if (nest_ff != NEST_MAX) begin
               nest_exec = nest_ff + NEST_W'(1);
            end
         end
         ACT_TICK, ACT_IEXIT: begin
            nest_exec  = nest_dec;
            sched_kind = KIND_INTR;
            do_sched   = (nest_dec == '0);
         end
         default: begin
            exec_mask = mask_ff;
         end
      endcase
   end

   // Lowest set bit of the updated bitmap is the highest priority task.
   always_comb begin
      found = 1'b0;
      sel   = '0;
      for (int i = NUM_TASKS - 1; i >= 0; i--) begin
         if (exec_mask[i]) begin
            found = 1'b1;
            sel   = TASK_W'(i);
         end
      end
   end

   // Reschedule and form the result.
   always_comb begin
      kind_c   = KIND_NONE;
      none_c   = 1'b0;
      cur_exec = cur_ff;
      if (do_start) begin
         if (found) begin
            cur_exec = sel;
         end else begin
            none_c = 1'b1;
         end
         kind_c = KIND_START;
      end else if (do_sched) begin
         if (!found) begin
            none_c = 1'b1;
         end else if (sel != cur_ff) begin
            cur_exec = sel;
            kind_c   = sched_kind;
         end
      end
      to_c = cur_exec;
   end

   // State register next values.
   always_comb begin
      mask_in = mask_ff;
      cur_in  = cur_ff;
      nest_in = nest_ff;
      time_in = time_ff;
      run_in  = run_ff;
      if (cmd.tick_begin) begin
         time_in = time_ff + TIME_W'(1);
         if (nest_ff != NEST_MAX) begin
            nest_in = nest_ff + NEST_W'(1);
         end
      end
      if (walk_wake) begin
         mask_in = mask_ff | (NUM_TASKS'(1) << rd_addr_ff);
      end
      if (cmd.exec) begin
         mask_in = exec_mask;
         cur_in  = cur_exec;
         nest_in = nest_exec;
         run_in  = run_ff || do_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         cur_ff  <= '0;
         nest_ff <= '0;
         time_ff <= '0;
         run_ff  <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         cur_ff  <= cur_in;
         nest_ff <= nest_in;
         time_ff <= time_in;
         run_ff  <= run_in;
      end
   end

   // Result staging, then the output register.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_kind_ff <= kind_c;
         res_from_ff <= cur_ff;
         res_to_ff   <= to_c;
         res_none_ff <= none_c;
         res_cur_ff  <= cur_exec;
         res_time_ff <= time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_switch_kind  <= res_kind_ff;
         rsp_from_task    <= res_from_ff;
         rsp_to_task      <= res_to_ff;
         rsp_none_ready   <= res_none_ff;
         rsp_current_task <= res_cur_ff;
         rsp_system_time  <= res_time_ff;
      end
   end

endmodule

// ===== tb/tb_bitmap_priority_task_scheduler.sv =====
// Testbench for the bitmap priority task scheduler: directed, hold-off, nesting and random tests.
// Predicts every response from its own scheduler model and checks each field in order.
// Depends on bpts_pkg, bpts_req_if, bpts_rsp_if and bitmap_priority_task_scheduler.
`timescale 1ns / 1ps

module tb_bitmap_priority_task_scheduler;
   import bpts_pkg::*;

   localparam int TASK_COUNT     = 32;
   localparam int TICK_LATENCY   = TASK_COUNT + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 500;
   localparam int HOLD_OFF       = 150;
   localparam int PRINT_LIMIT    = 100;

   // One predicted switch report.
   typedef struct packed {
      logic [KIND_W-1:0] switch_kind;
      logic [TASK_W-1:0] from_task;
      logic [TASK_W-1:0] to_task;
      logic              none_ready;
      logic [TASK_W-1:0] current_task;
      logic [TIME_W-1:0] system_time;
   } switch_report_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [TASK_W-1:0] csr_wr_data;

   bpts_req_if req_ch ();
   bpts_rsp_if rsp_ch ();

   bitmap_priority_task_scheduler #(
      .NUM_TASKS (TASK_COUNT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch),
      .rsp         (rsp_ch)
   );

   // Scheduler state as the testbench tracks it.
   logic [TASK_COUNT-1:0] ready_bits;
   logic [TIME_W-1:0]     delay_left [TASK_COUNT];
   logic [TASK_W-1:0]     running_task;
   logic [NEST_W-1:0]     nest_depth;
   logic [TIME_W-1:0]     tick_total;
   logic                  started;
   logic [TASK_W-1:0]     idle_prio;

   switch_report_type expected_reports [$];
   switch_report_type oldest_report;

   int error_count;
   int actions_sent;
   int reports_checked;
   int quiet_cycles;
   int rsp_hold_left;
   bit gaps_on;
   bit stalls_on;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Selects the lowest ready task; reports on_change when the running task changes.
   function automatic logic [KIND_W-1:0] reselect(input logic [KIND_W-1:0] on_change,
                                                  output logic [TASK_W-1:0] chosen,
                                                  output logic empty);
      int i;
      logic found;
      logic [TASK_W-1:0] sel;
      found  = 1'b0;
      sel    = '0;
      chosen = running_task;
      empty  = 1'b0;
      for (i = TASK_COUNT - 1; i >= 0; i--) begin
         if (ready_bits[i]) begin
            found = 1'b1;
            sel   = i[TASK_W-1:0];
         end
      end
      if (!found) begin
         empty = 1'b1;
         return KIND_NONE;
      end
      chosen = sel;
      if (sel != running_task) begin
         running_task = sel;
         return on_change;
      end
      return KIND_NONE;
   endfunction

   // Leaving an interrupt reschedules once the nesting depth is back at zero.
   function automatic logic [KIND_W-1:0] leave_interrupt(output logic [TASK_W-1:0] chosen,
                                                         output logic empty);
      chosen = running_task;
      empty  = 1'b0;
      if (nest_depth != '0)
         nest_depth--;
      if (nest_depth == '0)
         return reselect(KIND_INTR, chosen, empty);
      return KIND_NONE;
   endfunction

   // Applies one action to the tracked state and returns the report it causes.
   function automatic switch_report_type schedule_action(input logic [ACT_W-1:0] act,
                                                         input logic [TASK_W-1:0] id,
                                                         input logic [TIME_W-1:0] span);
      switch_report_type rep;
      logic [TASK_W-1:0] chosen;
      logic empty;
      logic [KIND_W-1:0] kind;
      int i;
      rep    = '0;
      chosen = running_task;
      empty  = 1'b0;
      kind   = KIND_NONE;
      rep.from_task = running_task;
      case (act)
         ACT_CREATE: begin
            if (id < TASK_COUNT) begin
               delay_left[id] = '0;
               ready_bits[id] = 1'b1;
            end
         end
         ACT_DELAY: begin
            if (span != '0) begin
               ready_bits[running_task] = 1'b0;
               delay_left[running_task] = span;
               kind = reselect(KIND_TASK, chosen, empty);
            end
         end
         ACT_SUSPEND: begin
            if (id < TASK_COUNT) begin
               delay_left[id] = '0;
               ready_bits[id] = 1'b0;
               if (running_task == id)
                  kind = reselect(KIND_TASK, chosen, empty);
            end
         end
         ACT_RESUME: begin
            if (id < TASK_COUNT) begin
               delay_left[id] = '0;
               ready_bits[id] = 1'b1;
               if (running_task > id)
                  kind = reselect(KIND_TASK, chosen, empty);
            end
         end
         ACT_TICK: begin
            if (nest_depth != NEST_MAX)
               nest_depth++;
            tick_total++;
            for (i = 0; i < TASK_COUNT; i++) begin
               if (delay_left[i] != '0) begin
                  delay_left[i]--;
                  if (delay_left[i] == '0)
                     ready_bits[i] = 1'b1;
               end
            end
            kind = leave_interrupt(chosen, empty);
         end
         ACT_START: begin
            if (!started) begin
               started = 1'b1;
               if (idle_prio < TASK_COUNT) begin
                  delay_left[idle_prio] = '0;
                  ready_bits[idle_prio] = 1'b1;
               end
               void'(reselect(KIND_START, chosen, empty));
               kind = KIND_START;
            end
         end
         ACT_IENTER: begin
            if (nest_depth != NEST_MAX)
               nest_depth++;
         end
         ACT_IEXIT: begin
            kind = leave_interrupt(chosen, empty);
         end
      endcase
      rep.switch_kind  = kind;
      rep.to_task      = chosen;
      rep.none_ready   = empty;
      rep.current_task = running_task;
      rep.system_time  = tick_total;
      return rep;
   endfunction

   // Prints one line per mismatch, up to a limit, and counts every one.
   task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                  input logic [TIME_W-1:0] want);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("%0t: response %0d, %s: got 0x%0h, expected 0x%0h",
                  $time, reports_checked, what, got, want);
   endtask

   // Offers one transaction, with an optional gap first, and predicts it on acceptance.
   task automatic send_action(input logic [ACT_W-1:0] act, input logic [TASK_W-1:0] id,
                              input logic [TIME_W-1:0] span);
      int gap;
      @(negedge clock);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.action      <= act;
      req_ch.task_id     <= id;
      req_ch.delay_ticks <= span;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expected_reports.push_back(schedule_action(act, id, span));
      actions_sent++;
   endtask

   // Stops offering and waits until every expected response has been seen.
   task automatic wait_for_quiet();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (TICK_LATENCY) @(posedge clock);
   endtask

   // Writes the idle task register; only called while the block is idle.
   task automatic write_idle_priority(input logic [TASK_W-1:0] prio);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= prio;
      @(posedge clock);
      idle_prio = prio;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Empty bitmap cases, start and restart, each action and the idle task setting.
   task automatic test_directed_cases();
      write_idle_priority(5'd0);
      write_idle_priority(5'd31);
      write_idle_priority(5'd20);
      send_action(ACT_IEXIT, 5'd0, 32'h0);
      send_action(ACT_TICK, 5'd31, 32'hFFFF_FFFF);
      send_action(ACT_DELAY, 5'd0, 32'h0);
      send_action(ACT_DELAY, 5'd0, 32'hFFFF_FFFF);
      send_action(ACT_CREATE, 5'd5, 32'h0);
      send_action(ACT_CREATE, 5'd31, 32'h0);
      send_action(ACT_START, 5'd0, 32'h0);
      send_action(ACT_START, 5'd0, 32'h0);
      send_action(ACT_RESUME, 5'd2, 32'h0);
      send_action(ACT_RESUME, 5'd9, 32'h0);
      send_action(ACT_SUSPEND, 5'd9, 32'h0);
      send_action(ACT_SUSPEND, 5'd2, 32'h0);
      send_action(ACT_DELAY, 5'd0, 32'd2);
      send_action(ACT_IENTER, 5'd0, 32'h0);
      send_action(ACT_TICK, 5'd0, 32'h0);
      send_action(ACT_IEXIT, 5'd0, 32'h0);
      send_action(ACT_TICK, 5'd0, 32'h0);
      send_action(ACT_SUSPEND, 5'd0, 32'h0);
      send_action(ACT_CREATE, 5'd0, 32'h0);
      send_action(ACT_IEXIT, 5'd0, 32'h0);
      send_action(ACT_DELAY, 5'd0, 32'h8000_0000);
      send_action(ACT_SUSPEND, 5'd31, 32'h0);
      send_action(ACT_RESUME, 5'd0, 32'h0);
      wait_for_quiet();
   endtask

   // The receiver holds off for a long stretch while the sender keeps offering.
   task automatic test_response_hold_off();
      int k;
      gaps_on       = 1'b0;
      rsp_hold_left = HOLD_OFF;
      for (k = 0; k < 16; k++)
         send_action(k[0] ? ACT_TICK : ACT_RESUME, TASK_W'($urandom_range(0, 31)),
                     $urandom());
      wait_for_quiet();
      write_idle_priority(5'd0);
   endtask

   // Drives the nesting depth into saturation and back down to zero.
   task automatic test_nesting_saturation();
      int k;
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      send_action(ACT_DELAY, 5'd0, 32'd1);
      for (k = 0; k < 258; k++)
         send_action(ACT_IENTER, 5'd0, 32'h0);
      send_action(ACT_TICK, 5'd0, 32'h0);
      for (k = 0; k < 255; k++)
         send_action(ACT_IEXIT, 5'd0, 32'h0);
      wait_for_quiet();
      write_idle_priority(5'd31);
   endtask

   // One random action, weighted towards creating, delaying and ticking.
   task automatic send_random_action();
      int pick;
      logic [TASK_W-1:0] id;
      logic [TIME_W-1:0] span;
      pick = $urandom_range(0, 99);
      id   = TASK_W'($urandom_range(0, 31));
      span = $urandom();
      if (pick < 14)
         send_action(ACT_CREATE, id, span);
      else if (pick < 25)
         send_action(ACT_DELAY, id, $urandom_range(1, 6));
      else if (pick < 27)
         send_action(ACT_DELAY, id, span);
      else if (pick < 36)
         send_action(ACT_SUSPEND, id, span);
      else if (pick < 46)
         send_action(ACT_RESUME, id, span);
      else if (pick < 72)
         send_action(ACT_TICK, id, span);
      else if (pick < 80)
         send_action(ACT_IENTER, id, span);
      else if (pick < 90)
         send_action(ACT_IEXIT, id, span);
      else if (pick < 92)
         send_action(ACT_START, id, span);
      else if (pick < 94)
         send_action(ACT_DELAY, id, 32'h0);
      else
         send_action(ACT_CREATE, id, span);
   endtask

   // Random mix in segments, with register writes between some and no idling at the end.
   task automatic test_random_mix(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if (k >= count - 120) begin
            gaps_on   = 1'b0;
            stalls_on = 1'b0;
         end else if (k % 60 == 0) begin
            gaps_on   = $urandom_range(0, 2) != 0;
            stalls_on = $urandom_range(0, 2) != 0;
         end
         if (k > 0 && k % 150 == 0 && k < count - 120) begin
            wait_for_quiet();
            write_idle_priority(TASK_W'($urandom_range(0, 31)));
         end
         send_random_action();
      end
   endtask

   // Receiver: honours a requested hold-off, otherwise stalls in random bursts.
   initial begin
      int stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Checks each accepted response against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("response with none expected", TIME_W'(rsp_ch.current_task),
                            '0);
         end else begin
            oldest_report = expected_reports.pop_front();
            if (rsp_ch.switch_kind !== oldest_report.switch_kind)
               report_mismatch("switch_kind", TIME_W'(rsp_ch.switch_kind),
                               TIME_W'(oldest_report.switch_kind));
            if (rsp_ch.from_task !== oldest_report.from_task)
               report_mismatch("from_task", TIME_W'(rsp_ch.from_task),
                               TIME_W'(oldest_report.from_task));
            if (rsp_ch.to_task !== oldest_report.to_task)
               report_mismatch("to_task", TIME_W'(rsp_ch.to_task),
                               TIME_W'(oldest_report.to_task));
            if (rsp_ch.none_ready !== oldest_report.none_ready)
               report_mismatch("none_ready", TIME_W'(rsp_ch.none_ready),
                               TIME_W'(oldest_report.none_ready));
            if (rsp_ch.current_task !== oldest_report.current_task)
               report_mismatch("current_task", TIME_W'(rsp_ch.current_task),
                               TIME_W'(oldest_report.current_task));
            if (rsp_ch.system_time !== oldest_report.system_time)
               report_mismatch("system_time", rsp_ch.system_time, oldest_report.system_time);
         end
         reports_checked++;
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
                  WATCHDOG_LIMIT, expected_reports.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   // Reset, then the tests in turn, then the verdict.
   initial begin
      int i;
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.action      = ACT_CREATE;
      req_ch.task_id     = '0;
      req_ch.delay_ticks = '0;
      ready_bits         = '0;
      for (i = 0; i < TASK_COUNT; i++)
         delay_left[i] = '0;
      running_task    = '0;
      nest_depth      = '0;
      tick_total      = '0;
      started         = 1'b0;
      idle_prio       = IDLE_RESET;
      error_count     = 0;
      actions_sent    = 0;
      reports_checked = 0;
      quiet_cycles    = 0;
      rsp_hold_left   = 0;
      gaps_on         = 1'b1;
      stalls_on       = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_response_hold_off();
      test_nesting_saturation();
      test_random_mix(RANDOM_ITEMS);
      wait_for_quiet();

      $display("Sent %0d scheduler actions and checked %0d responses, %0d mismatches.",
               actions_sent, reports_checked, error_count);
      $display("Covered every action, restart, nesting saturation and a long response hold-off.");
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
